FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define CGG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CGG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/cgg_pkg.sv
// ----------------------------------------------------------------------------
// cgg_pkg
// Shared widths and types of the complex Givens generator.
// ----------------------------------------------------------------------------
package cgg_pkg;

  localparam int RW       = 208;     // root recurrence datapath, signed
  localparam int NB       = 35;      // result bits of the rounded root
  localparam int ROOT_LAT = NB + 1;  // init stage plus one stage per bit
  localparam int MW       = 65;      // wide multiplier operand
  localparam int PW       = 2 * MW;  // wide multiplier product
  localparam int IDW      = 128;     // input word
  localparam int ODW      = 168;     // output word, padded to bytes

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    logic        bz;       // b is zero
    logic        az;       // a is zero, b is not
    logic        sre_neg;
    logic        sim_neg;
    logic [31:0] a_re;
    logic [31:0] a_im;
  } meta_t;

endpackage

FILE: src/complex_givens_generator.sv
// ----------------------------------------------------------------------------
// complex_givens_generator
// Complex Givens rotation (c, s, r) from complex a and b, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one word per cycle while the output is
// not stalled. From input accept to output valid a word passes seven front
// stages (magnitudes, 32-bit products, sums, |a|^2+|b|^2, a two-stage wide
// multiplier, operand select), 36 stages of the exact rounded square-root
// recurrence (one result bit per stage), and the output register. A stalled
// output holds one extra word in a skid entry before input ready drops.
module complex_givens_generator (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // a_re[31:0], a_im[63:32], b_re[95:64], b_im[127:96]
  input  logic [cgg_pkg::IDW-1:0] s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // cosine[30:0], sine_re[62:31], sine_im[94:63], r_re[128:95],
  // r_im[162:129], zero[167:163]
  output logic [cgg_pkg::ODW-1:0] m_axis_tdata_o
);

  localparam int RW    = cgg_pkg::RW;
  localparam int NB    = cgg_pkg::NB;
  localparam int LAT   = cgg_pkg::ROOT_LAT;
  localparam int FRONT = 7;
  localparam int DEPTH = FRONT + LAT;

  typedef struct packed {
    logic [31:0] ar, ai, br, bi;
    logic        anr, ani, bnr, bni;
    logic        bz, az;
    logic [31:0] a_re, a_im;
  } s1_t;

  typedef struct packed {
    logic [63:0] ar2, ai2, br2, bi2, brar, biai, brai, biar;
    logic        anr, ani, bnr, bni;
    logic        bz, az;
    logic [31:0] a_re, a_im;
  } s2_t;

  typedef struct packed {
    logic [63:0] f2, g2, br2, bi2;
    logic [64:0] h;
    logic        nre, nim, bnr, bni;
    logic        bz, az;
    logic [31:0] a_re, a_im;
  } side_t;

  typedef struct packed {
    side_t       sd;
    logic [63:0] sre, sim, ar2, ai2;
  } s3_t;

  logic             en;
  logic [DEPTH-1:0] vld_q;
  s1_t              p1_q, p1_d;
  s2_t              p2_q, p2_d;
  s3_t              p3_q, p3_d;
  s3_t              p4_q, p4_d;
  side_t            p5_q, p6_q;
  logic [RW-1:0]    num_q [5];
  logic [RW-1:0]    den_q [5];
  logic [RW-1:0]    num_d [5];
  logic [RW-1:0]    den_d [5];
  cgg_pkg::meta_t   m7_q, m7_d;
  cgg_pkg::meta_t   mt_q [LAT];
  logic [cgg_pkg::PW-1:0] prod [5];
  logic [NB-1:0]    rn [5];
  logic [cgg_pkg::ODW-1:0] res;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // {neg, |(+-p) + (+-q)|}
  function automatic logic [64:0] ssum(logic [63:0] p, logic pn, logic [63:0] q, logic qn);
    logic signed [65:0] sp;
    logic signed [65:0] sq;
    logic signed [65:0] sv;
    logic        [65:0] mg;
    sp = pn ? -$signed({2'b0, p}) : $signed({2'b0, p});
    sq = qn ? -$signed({2'b0, q}) : $signed({2'b0, q});
    sv = sp + sq;
    mg = sv[65] ? 66'(-sv) : 66'(sv);
    return {sv[65], mg[63:0]};
  endfunction

  function automatic logic [NB-1:0] apply_sign(logic [NB-1:0] m, logic ng);
    return ng ? (~m + NB'(1)) : m;
  endfunction

  // stage 1: magnitudes and case flags
  always_comb begin
    p1_d.a_re = s_axis_tdata_i[31:0];
    p1_d.a_im = s_axis_tdata_i[63:32];
    p1_d.ar   = mag32(s_axis_tdata_i[31:0]);
    p1_d.ai   = mag32(s_axis_tdata_i[63:32]);
    p1_d.br   = mag32(s_axis_tdata_i[95:64]);
    p1_d.bi   = mag32(s_axis_tdata_i[127:96]);
    p1_d.anr  = s_axis_tdata_i[31];
    p1_d.ani  = s_axis_tdata_i[63];
    p1_d.bnr  = s_axis_tdata_i[95];
    p1_d.bni  = s_axis_tdata_i[127];
    p1_d.bz   = (s_axis_tdata_i[127:64] == 64'd0);
    p1_d.az   = (s_axis_tdata_i[63:0] == 64'd0) && !p1_d.bz;
  end

  // stage 2: 32-bit products
  always_comb begin
    p2_d.ar2  = 64'(p1_q.ar) * 64'(p1_q.ar);
    p2_d.ai2  = 64'(p1_q.ai) * 64'(p1_q.ai);
    p2_d.br2  = 64'(p1_q.br) * 64'(p1_q.br);
    p2_d.bi2  = 64'(p1_q.bi) * 64'(p1_q.bi);
    p2_d.brar = 64'(p1_q.br) * 64'(p1_q.ar);
    p2_d.biai = 64'(p1_q.bi) * 64'(p1_q.ai);
    p2_d.brai = 64'(p1_q.br) * 64'(p1_q.ai);
    p2_d.biar = 64'(p1_q.bi) * 64'(p1_q.ar);
    p2_d.anr  = p1_q.anr;
    p2_d.ani  = p1_q.ani;
    p2_d.bnr  = p1_q.bnr;
    p2_d.bni  = p1_q.bni;
    p2_d.bz   = p1_q.bz;
    p2_d.az   = p1_q.az;
    p2_d.a_re = p1_q.a_re;
    p2_d.a_im = p1_q.a_im;
  end

  // stage 3: |a|^2, |b|^2 and conj(b)*a
  always_comb begin
    logic [64:0] sr;
    logic [64:0] si;
    sr = ssum(p2_q.brar, p2_q.bnr ^ p2_q.anr, p2_q.biai, p2_q.bni ^ p2_q.ani);
    si = ssum(p2_q.brai, p2_q.bnr ^ p2_q.ani, p2_q.biar, !(p2_q.bni ^ p2_q.anr));
    p3_d.sd.f2   = p2_q.ar2 + p2_q.ai2;
    p3_d.sd.g2   = p2_q.br2 + p2_q.bi2;
    p3_d.sd.br2  = p2_q.br2;
    p3_d.sd.bi2  = p2_q.bi2;
    p3_d.sd.h    = '0;
    p3_d.sd.nre  = sr[64];
    p3_d.sd.nim  = si[64];
    p3_d.sd.bnr  = p2_q.bnr;
    p3_d.sd.bni  = p2_q.bni;
    p3_d.sd.bz   = p2_q.bz;
    p3_d.sd.az   = p2_q.az;
    p3_d.sd.a_re = p2_q.a_re;
    p3_d.sd.a_im = p2_q.a_im;
    p3_d.sre     = sr[63:0];
    p3_d.sim     = si[63:0];
    p3_d.ar2     = p2_q.ar2;
    p3_d.ai2     = p2_q.ai2;
  end

  // stage 4: h = |a|^2 + |b|^2
  always_comb begin
    p4_d      = p3_q;
    p4_d.sd.h = {1'b0, p3_q.sd.f2} + {1'b0, p3_q.sd.g2};
  end

  cgg_wmul u_mul_sre (
    .clk_i(clk_i), .en_i(en), .a_i({1'b0, p4_q.sre}), .b_i({1'b0, p4_q.sre}), .p_o(prod[0])
  );
  cgg_wmul u_mul_sim (
    .clk_i(clk_i), .en_i(en), .a_i({1'b0, p4_q.sim}), .b_i({1'b0, p4_q.sim}), .p_o(prod[1])
  );
  cgg_wmul u_mul_fh (
    .clk_i(clk_i), .en_i(en), .a_i({1'b0, p4_q.sd.f2}), .b_i(p4_q.sd.h), .p_o(prod[2])
  );
  cgg_wmul u_mul_arh (
    .clk_i(clk_i), .en_i(en), .a_i({1'b0, p4_q.ar2}), .b_i(p4_q.sd.h), .p_o(prod[3])
  );
  cgg_wmul u_mul_aih (
    .clk_i(clk_i), .en_i(en), .a_i({1'b0, p4_q.ai2}), .b_i(p4_q.sd.h), .p_o(prod[4])
  );

  // stage 7: root operands per output; unit order c, s_re, s_im, r_re, r_im
  always_comb begin
    for (int u = 0; u < 5; u++) begin
      num_d[u] = '0;
      den_d[u] = RW'(1);
    end
    if (p6_q.az) begin
      num_d[1] = RW'(p6_q.br2) << 62;
      den_d[1] = RW'(p6_q.g2);
      num_d[2] = RW'(p6_q.bi2) << 62;
      den_d[2] = RW'(p6_q.g2);
      num_d[3] = RW'(p6_q.g2) << 2;
    end else if (!p6_q.bz) begin
      num_d[0] = RW'(p6_q.f2) << 62;
      den_d[0] = RW'(p6_q.h);
      num_d[1] = RW'(prod[0]) << 62;
      den_d[1] = RW'(prod[2]);
      num_d[2] = RW'(prod[1]) << 62;
      den_d[2] = RW'(prod[2]);
      num_d[3] = RW'(prod[3]) << 2;
      den_d[3] = RW'(p6_q.f2);
      num_d[4] = RW'(prod[4]) << 2;
      den_d[4] = RW'(p6_q.f2);
    end
    m7_d.bz      = p6_q.bz;
    m7_d.az      = p6_q.az;
    m7_d.sre_neg = p6_q.az ? p6_q.bnr : p6_q.nre;
    m7_d.sim_neg = p6_q.az ? !p6_q.bni : p6_q.nim;
    m7_d.a_re    = p6_q.a_re;
    m7_d.a_im    = p6_q.a_im;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      p3_q  <= p3_d;
      p4_q  <= p4_d;
      p5_q  <= p4_q.sd;
      p6_q  <= p5_q;
      num_q <= num_d;
      den_q <= den_d;
      m7_q  <= m7_d;
      mt_q[0] <= m7_q;
      for (int i = 1; i < LAT; i++) begin
        mt_q[i] <= mt_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid_i};
    end
  end

  for (genvar u = 0; u < 5; u++) begin : g_root
    cgg_root u_root (
      .clk_i (clk_i),
      .en_i  (en),
      .num4_i(num_q[u]),
      .den_i (den_q[u]),
      .n_o   (rn[u])
    );
  end

  // sign and special cases
  always_comb begin
    cgg_pkg::meta_t m;
    logic [NB-1:0]  sre;
    logic [NB-1:0]  sim;
    logic [NB-1:0]  rre;
    logic [NB-1:0]  rim;
    m   = mt_q[LAT-1];
    sre = apply_sign(rn[1], m.sre_neg);
    sim = apply_sign(rn[2], m.sim_neg);
    rre = apply_sign(rn[3], m.a_re[31] && !m.az);
    rim = apply_sign(rn[4], m.a_im[31]);
    res = '0;
    if (m.bz) begin
      res[30:0]    = cgg_pkg::ONE_Q30;
      res[128:95]  = {{2{m.a_re[31]}}, m.a_re};
      res[162:129] = {{2{m.a_im[31]}}, m.a_im};
    end else begin
      res[30:0]   = m.az ? 31'd0 : rn[0][30:0];
      res[62:31]  = sre[31:0];
      res[94:63]  = sim[31:0];
      res[128:95] = rre[33:0];
      res[162:129] = m.az ? 34'd0 : rim[33:0];
    end
  end

  cgg_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vld_q[DEPTH-1]),
    .in_ready_o (en),
    .in_data_i  (res),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o)
  );

  assign s_axis_tready_o = en;

endmodule

FILE: src/cgg_wmul.sv
// ----------------------------------------------------------------------------
// cgg_wmul
// Two-stage 65x65 unsigned multiplier built from four partial products.
// ----------------------------------------------------------------------------
module cgg_wmul (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [cgg_pkg::MW-1:0] a_i,
  input  logic [cgg_pkg::MW-1:0] b_i,
  output logic [cgg_pkg::PW-1:0] p_o
);

  logic [63:0] ll_q;
  logic [64:0] lh_q;
  logic [64:0] hl_q;
  logic [65:0] hh_q;
  logic [cgg_pkg::PW-1:0] p_q;
  logic [cgg_pkg::PW-1:0] p_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= {32'b0, a_i[31:0]} * {32'b0, b_i[31:0]};
      lh_q <= {33'b0, a_i[31:0]} * {32'b0, b_i[64:32]};
      hl_q <= {32'b0, a_i[64:32]} * {33'b0, b_i[31:0]};
      hh_q <= {33'b0, a_i[64:32]} * {33'b0, b_i[64:32]};
      p_q  <= p_d;
    end
  end

  always_comb begin
    p_d = cgg_pkg::PW'(ll_q)
        + (cgg_pkg::PW'(lh_q) << 32)
        + (cgg_pkg::PW'(hl_q) << 32)
        + (cgg_pkg::PW'(hh_q) << 64);
  end

  assign p_o = p_q;

endmodule

FILE: src/cgg_root.sv
// ----------------------------------------------------------------------------
// cgg_root
// Pipelined round(sqrt(num/den)), one result bit per stage.
// Takes 4*num; keeps R = 4num - (2n-1)^2 den and Y = (2n-1) den.
// ----------------------------------------------------------------------------
module cgg_root (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [cgg_pkg::RW-1:0] num4_i,
  input  logic [cgg_pkg::RW-1:0] den_i,
  output logic [cgg_pkg::NB-1:0] n_o
);

  localparam int NB = cgg_pkg::NB;
  localparam int RW = cgg_pkg::RW;

  logic signed [RW-1:0] r_q [NB];
  logic signed [RW-1:0] y_q [NB];
  logic        [RW-1:0] d_q [NB];
  logic        [NB-1:0] n_q [NB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= $signed(num4_i) - $signed(den_i);
      y_q[0] <= -$signed(den_i);
      d_q[0] <= den_i;
      n_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_stage
    localparam int K = NB - 1 - i;
    logic signed [RW-1:0] t;
    logic                 acc;

    assign t   = (y_q[i] + $signed(d_q[i] << K)) <<< (K + 2);
    assign acc = (r_q[i] >= t);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i+1] <= acc ? (n_q[i] | (NB'(1) << K)) : n_q[i];
      end
    end

    if (i < NB - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[i+1] <= acc ? (r_q[i] - t) : r_q[i];
          y_q[i+1] <= acc ? (y_q[i] + $signed(d_q[i] << (K + 1))) : y_q[i];
          d_q[i+1] <= d_q[i];
        end
      end
    end
  end

  assign n_o = n_q[NB];

endmodule

FILE: src/cgg_skid.sv
// ----------------------------------------------------------------------------
// cgg_skid
// Output register with one skid entry; ready toward the pipeline is registered.
// ----------------------------------------------------------------------------
module cgg_skid (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [cgg_pkg::ODW-1:0] in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [cgg_pkg::ODW-1:0] out_data_o
);

  logic                    out_v_q;
  logic                    skid_v_q;
  logic [cgg_pkg::ODW-1:0] out_q;
  logic [cgg_pkg::ODW-1:0] skid_q;
  logic                    take;

  assign in_ready_o = !skid_v_q;
  assign take       = in_valid_i && !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      if (!out_v_q || out_ready_i) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_v_q  <= skid_v_q;
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (!out_v_q || out_ready_i) begin
        out_q <= in_data_i;
      end else begin
        skid_q <= in_data_i;
      end
    end else if (out_ready_i && skid_v_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/cgg_checker.sv
// ----------------------------------------------------------------------------
// cgg_checker
// Port-level checks of the complex Givens generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cgg_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid_i,
  input logic                    s_axis_tready_o,
  input logic [cgg_pkg::IDW-1:0] s_axis_tdata_i,
  input logic                    m_axis_tvalid_o,
  input logic                    m_axis_tready_i,
  input logic [cgg_pkg::ODW-1:0] m_axis_tdata_o
);

  `CGG_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o, "output valid in reset")
  `CGG_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled word changed")
  `CGG_ASSERT(a_cos_range, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tdata_o[30:0] <= 31'h4000_0000, "cosine above one")
  `CGG_ASSERT(a_sin_range, clk_i, rst_ni, m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[62:31]) <= 32'sh4000_0000 && $signed(m_axis_tdata_o[62:31]) >= -32'sh4000_0000), "sine out of range")
  `CGG_ASSERT(a_ready_drop, clk_i, rst_ni, !s_axis_tready_o |-> $past(m_axis_tvalid_o && !m_axis_tready_i), "ready dropped without output stall")

endmodule

bind complex_givens_generator cgg_checker u_cgg_checker (.*);
